// ===== hw/rtl/hec_pkg.sv =====
// Shared types, constants and code-construction functions for the Hamming encoder/corrector.
`default_nettype none

package hec_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W = 57;
    localparam int CODE_W = 63;
    localparam int SYN_W  = 6;
    localparam int LEN_W  = 6;

    // Action codes carried with every item.
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // Control that travels beside the payload through the pipeline.
    typedef struct packed {
        logic             valid;
        logic             action;
        logic [LEN_W-1:0] code_len;
    } hec_ctrl_t;

    // Smallest r with m + r + 1 <= 2^r; the condition fails monotonically in r.
    function automatic logic [2:0] parity_count(input logic [LEN_W-1:0] m);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if ((8'(m) + 8'(i) + 8'd1) > (8'd1 << i)) begin
                r = 3'(i + 1);
            end
        end
        return r;
    endfunction

    // Place data bits, first bit first, at the positions that are not powers of two.
    function automatic logic [CODE_W-1:0] scatter_data(input logic [DATA_W-1:0] data);
        logic [CODE_W-1:0] code;
        int                j;
        code = '0;
        j    = 0;
        for (int p = 1; p <= CODE_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                code[p-1] = data[j];
                j++;
            end
        end
        return code;
    endfunction

    // Ones on the positions 1..n, that is bits 0..n-1.
    function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] n);
        logic [CODE_W-1:0] mask;
        for (int b = 0; b < CODE_W; b++) begin
            mask[b] = (7'(b) < 7'(n));
        end
        return mask;
    endfunction

    // XOR of the position numbers of all set bits.
    function automatic logic [SYN_W-1:0] word_syndrome(input logic [CODE_W-1:0] word);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int p = 1; p <= CODE_W; p++) begin
            if (word[p-1]) begin
                s = s ^ SYN_W'(p);
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hec_prep.sv =====
// Front stages: capture the item with its code length, then build the masked working word.
`default_nettype none

module hec_prep
    import hec_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_action,
    input  wire logic [DATA_W-1:0] in_data,
    input  wire logic [CODE_W-1:0] in_code,
    input  wire logic [LEN_W-1:0]  msg_len,
    output hec_ctrl_t              out_ctrl,
    output logic      [CODE_W-1:0] out_word
);

    hec_ctrl_t         a_ctrl_next;
    hec_ctrl_t         a_ctrl_reg;
    logic [DATA_W-1:0] a_data_reg;
    logic [CODE_W-1:0] a_code_reg;
    hec_ctrl_t         b_ctrl_reg;
    logic [CODE_W-1:0] b_word_next;
    logic [CODE_W-1:0] b_word_reg;

    // Code length n = m + r for the current message length.
    always_comb
    begin
        a_ctrl_next.valid    = in_valid;
        a_ctrl_next.action   = in_action;
        a_ctrl_next.code_len = msg_len + LEN_W'(parity_count(msg_len));
    end

    // Data bits go to their fixed positions; both actions are cut to n bits.
    always_comb
    begin
        if (a_ctrl_reg.action == ACT_DECODE) begin
            b_word_next = a_code_reg & low_mask(a_ctrl_reg.code_len);
        end else begin
            b_word_next = scatter_data(a_data_reg) & low_mask(a_ctrl_reg.code_len);
        end
    end

    // Valid bits are reset; the rest of the control follows them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_ctrl_reg <= '0;
            b_ctrl_reg <= '0;
        end else begin
            a_ctrl_reg <= a_ctrl_next;
            b_ctrl_reg <= a_ctrl_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_data_reg <= in_data;
        a_code_reg <= in_code;
        b_word_reg <= b_word_next;
    end

    assign out_ctrl = b_ctrl_reg;
    assign out_word = b_word_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hec_syndrome.sv =====
// Syndrome stage: XOR of the positions of all set bits of the working word.
`default_nettype none

module hec_syndrome
    import hec_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hec_ctrl_t         in_ctrl,
    input  wire logic [CODE_W-1:0] in_word,
    output hec_ctrl_t              out_ctrl,
    output logic      [CODE_W-1:0] out_word,
    output logic      [SYN_W-1:0]  out_syn
);

    hec_ctrl_t         ctrl_reg;
    logic [CODE_W-1:0] word_reg;
    logic [SYN_W-1:0]  syn_next;
    logic [SYN_W-1:0]  syn_reg;

    // One XOR tree per syndrome bit.
    always_comb
    begin
        syn_next = word_syndrome(in_word);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= in_word;
        syn_reg  <= syn_next;
    end

    assign out_ctrl = ctrl_reg;
    assign out_word = word_reg;
    assign out_syn  = syn_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hec_fix.sv =====
// Output stage: insert parity on encode; on decode, flip the addressed bit or flag it.
`default_nettype none

module hec_fix
    import hec_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hec_ctrl_t         in_ctrl,
    input  wire logic [CODE_W-1:0] in_word,
    input  wire logic [SYN_W-1:0]  in_syn,
    output logic                   done,
    output logic      [CODE_W-1:0] code_out,
    output logic      [SYN_W-1:0]  syndrome,
    output logic                   syndrome_out_of_range
);

    logic              done_reg;
    logic [CODE_W-1:0] code_next;
    logic [CODE_W-1:0] code_reg;
    logic [SYN_W-1:0]  syn_next;
    logic [SYN_W-1:0]  syn_reg;
    logic              flag_next;
    logic              flag_reg;
    logic              action_reg;
    logic [LEN_W-1:0]  len_reg;

    // Parity positions are zero in the encode word, so the syndrome bits are the parity bits.
    always_comb
    begin
        code_next = in_word;
        syn_next  = '0;
        flag_next = 1'b0;
        if (in_ctrl.action == ACT_ENCODE) begin
            for (int i = 0; i < SYN_W; i++) begin
                if (in_syn[i]) begin
                    code_next[(1 << i) - 1] = 1'b1;
                end
            end
        end else begin
            syn_next = in_syn;
            if (in_syn != '0) begin
                if (in_syn <= in_ctrl.code_len) begin
                    code_next[in_syn - SYN_W'(1)] = ~in_word[in_syn - SYN_W'(1)];
                end else begin
                    flag_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= in_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        syn_reg    <= syn_next;
        flag_reg   <= flag_next;
        action_reg <= in_ctrl.action;
        len_reg    <= in_ctrl.code_len;
    end

    assign done                  = done_reg;
    assign code_out              = code_reg;
    assign syndrome              = syn_reg;
    assign syndrome_out_of_range = flag_reg;

    // A flagged syndrome is nonzero and lies beyond the code length.
    a_flag_beyond_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && flag_reg) |-> (syn_reg != '0 && syn_reg > len_reg))
        else $error("out-of-range flag with syndrome inside the code");

    // Nothing is written above the code length.
    a_no_high_bits: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ((code_reg & ~low_mask(len_reg)) == '0))
        else $error("code_out has bits above the code length");

    // Encode reports no syndrome and no flag.
    a_encode_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && action_reg == ACT_ENCODE) |-> (syn_reg == '0 && !flag_reg))
        else $error("encode result carries a syndrome");

    // A correction changes exactly one bit of the masked working word.
    a_single_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ctrl.valid && in_ctrl.action == ACT_DECODE && in_syn != '0
            && in_syn <= in_ctrl.code_len)
        |=> ($countones(code_reg ^ $past(in_word)) == 1))
        else $error("correction did not flip exactly one bit");

endmodule

`default_nettype wire

// ===== hw/rtl/hamming_encode_correct_core.sv =====
// Top level of the Hamming single-error-correcting encoder and corrector.
//
// Usage: an item (action, data_bits, received_code) transfers at a rising edge
// where start is high and busy is low. busy is always low: the pipeline takes
// one item every cycle. action 0 encodes the first m bits of data_bits; action
// 1 checks received_code over its first n = m + r positions and corrects a
// single error. Each result appears on code_out, syndrome and
// syndrome_out_of_range for exactly one cycle with done high, after passing
// through the capture, masking, syndrome and output registers (the
// capture register loading at the start edge); one result per cycle at full load.
// The receiver cannot stall, so results are never held back.
// cfg_write with cfg_data sets the message length m (0 acts as 1, values above
// MAX_DATA_BITS act as MAX_DATA_BITS); change it only with the pipeline empty.
// Reset sets m to 4 and clears all valid bits; no result is produced until
// an item has started.
`default_nettype none

module hamming_encode_correct_core
    import hec_pkg::*;
#(
    parameter int MAX_DATA_BITS = 57
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [LEN_W-1:0]  cfg_data,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              action,
    input  wire logic [DATA_W-1:0] data_bits,
    input  wire logic [CODE_W-1:0] received_code,
    output logic                   done,
    output logic      [CODE_W-1:0] code_out,
    output logic      [SYN_W-1:0]  syndrome,
    output logic                   syndrome_out_of_range
);

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_DATA_BITS);

    logic [LEN_W-1:0] msg_len_reg;
    logic [LEN_W-1:0] msg_len_used;
    hec_ctrl_t        prep_ctrl;
    logic [CODE_W-1:0] prep_word;
    hec_ctrl_t        syn_ctrl;
    logic [CODE_W-1:0] syn_word;
    logic [SYN_W-1:0] syn_value;

    // Message length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            msg_len_reg <= LEN_W'(4);
        end else if (cfg_write) begin
            msg_len_reg <= cfg_data;
        end
    end

    // Clamp the length to the supported range.
    always_comb
    begin
        if (msg_len_reg == '0) begin
            msg_len_used = LEN_W'(1);
        end else if (msg_len_reg > MaxLen) begin
            msg_len_used = MaxLen;
        end else begin
            msg_len_used = msg_len_reg;
        end
    end

    assign busy = 1'b0;

    hec_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_action (action),
        .in_data   (data_bits),
        .in_code   (received_code),
        .msg_len   (msg_len_used),
        .out_ctrl  (prep_ctrl),
        .out_word  (prep_word)
    );

    hec_syndrome u_syndrome (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctrl  (prep_ctrl),
        .in_word  (prep_word),
        .out_ctrl (syn_ctrl),
        .out_word (syn_word),
        .out_syn  (syn_value)
    );

    hec_fix u_fix (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_ctrl               (syn_ctrl),
        .in_word               (syn_word),
        .in_syn                (syn_value),
        .done                  (done),
        .code_out              (code_out),
        .syndrome              (syndrome),
        .syndrome_out_of_range (syndrome_out_of_range)
    );

endmodule

`default_nettype wire

// ===== bench/hamming_checker.sv =====
// Checker that predicts every Hamming encode and correct result and compares the DUT against it.
`timescale 1ns / 1ps

module hamming_checker
    import hec_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [LEN_W-1:0]  cfg_data,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic              action,
    input  wire logic [DATA_W-1:0] data_bits,
    input  wire logic [CODE_W-1:0] received_code,
    input  wire logic              done,
    input  wire logic [CODE_W-1:0] code_out,
    input  wire logic [SYN_W-1:0]  syndrome,
    input  wire logic              syndrome_out_of_range,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [SYN_W-1:0]  syn;
        logic              range_err;
    } codeword_result_t;

    codeword_result_t  expected_words[$];
    logic [LEN_W-1:0]  msg_len;

    // XOR of the position numbers of the set bits among positions 1..n.
    function automatic int position_xor(input logic [CODE_W-1:0] word, input int n);
        int s;
        s = 0;
        for (int p = 1; p <= n; p++) begin
            if (word[p-1])
            begin
                s = s ^ p;
            end
        end
        return s;
    endfunction

    // Expected result of one transfer under the given message length.
    function automatic codeword_result_t predict_hamming(input logic act,
                                                         input logic [DATA_W-1:0] data,
                                                         input logic [CODE_W-1:0] rx,
                                                         input logic [LEN_W-1:0] len);
        codeword_result_t res;
        int m;
        int r;
        int n;
        int j;
        int s;
        m = int'(len);
        if (m < 1) m = 1;
        if (m > DATA_W) m = DATA_W;
        r = 0;
        while (m + r + 1 > (1 << r)) r++;
        n = m + r;
        res = '0;
        if (act == ACT_ENCODE)
        begin
            // Data bits go to the positions that are not powers of two.
            j = 0;
            for (int p = 1; p <= n; p++) begin
                if ((p & (p - 1)) != 0)
                begin
                    res.code[p-1] = data[j];
                    j++;
                end
            end
            s = position_xor(res.code, n);
            for (int i = 0; i < r; i++) begin
                if (s[i]) res.code[(1 << i) - 1] = 1'b1;
            end
        end
        else
        begin
            // Keep positions 1..n, then correct the addressed bit if it exists.
            for (int p = 1; p <= n; p++) begin
                res.code[p-1] = rx[p-1];
            end
            s = position_xor(res.code, n);
            res.syn = SYN_W'(s);
            if (s != 0)
            begin
                if (s <= n) res.code[s-1] = ~res.code[s-1];
                else res.range_err = 1'b1;
            end
        end
        return res;
    endfunction

    // Track the length register, queue predictions, and compare each result.
    always @(posedge clk or negedge rst_n) begin
        codeword_result_t exp_word;
        if (!rst_n)
        begin
            msg_len = LEN_W'(4);
            expected_words.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result with nothing expected: code %h syn %0d flag %0b",
                                 $realtime, code_out, syndrome, syndrome_out_of_range);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_word = expected_words.pop_front();
                    if (code_out !== exp_word.code || syndrome !== exp_word.syn ||
                        syndrome_out_of_range !== exp_word.range_err)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch: expected code %h syn %0d flag %0b,",
                                     $realtime, exp_word.code, exp_word.syn,
                                     exp_word.range_err,
                                     " got code %h syn %0d flag %0b",
                                     code_out, syndrome, syndrome_out_of_range);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_words.push_back(predict_hamming(action, data_bits, received_code,
                                                         msg_len));
            if (cfg_write) msg_len = cfg_data;
            pending <= expected_words.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the Hamming encode and correct testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import hec_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic [LEN_W-1:0]  cfg_data = '0;
    logic              start = 1'b0;
    logic              busy;
    logic              action = ACT_ENCODE;
    logic [DATA_W-1:0] data_bits = '0;
    logic [CODE_W-1:0] received_code = '0;
    logic              done;
    logic [CODE_W-1:0] code_out;
    logic [SYN_W-1:0]  syndrome;
    logic              syndrome_out_of_range;
    int                fail_count;
    int                pending;

    logic [LEN_W-1:0]  cur_len = LEN_W'(4);
    bit                gaps_on = 1'b1;

    always #6 clk = ~clk;

    hamming_encode_correct_core dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write             (cfg_write),
        .cfg_data              (cfg_data),
        .start                 (start),
        .busy                  (busy),
        .action                (action),
        .data_bits             (data_bits),
        .received_code         (received_code),
        .done                  (done),
        .code_out              (code_out),
        .syndrome              (syndrome),
        .syndrome_out_of_range (syndrome_out_of_range)
    );

    hamming_checker u_checker (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write             (cfg_write),
        .cfg_data              (cfg_data),
        .start                 (start),
        .busy                  (busy),
        .action                (action),
        .data_bits             (data_bits),
        .received_code         (received_code),
        .done                  (done),
        .code_out              (code_out),
        .syndrome              (syndrome),
        .syndrome_out_of_range (syndrome_out_of_range),
        .fail_count            (fail_count),
        .pending               (pending)
    );

    function automatic logic [CODE_W-1:0] random_word();
        return CODE_W'({$urandom, $urandom});
    endfunction

    // Code length n = m + r for a register value, with the same clamping as the block.
    function automatic int code_length(input logic [LEN_W-1:0] len);
        int m;
        int r;
        m = int'(len);
        if (m < 1) m = 1;
        if (m > DATA_W) m = DATA_W;
        r = 0;
        while (m + r + 1 > (1 << r)) r++;
        return m + r;
    endfunction

    function automatic logic [CODE_W-1:0] low_positions(input int n);
        return CODE_W'((64'd1 << n) - 64'd1);
    endfunction

    // Random word over positions 1..n, with parity positions fixed so its syndrome is zero.
    function automatic logic [CODE_W-1:0] valid_codeword(input int n);
        logic [CODE_W-1:0] w;
        int s;
        w = random_word() & low_positions(n);
        s = 0;
        for (int p = 1; p <= n; p++) begin
            if (w[p-1]) s = s ^ p;
        end
        for (int i = 0; i < SYN_W; i++) begin
            if (s[i]) w[(1 << i) - 1] = ~w[(1 << i) - 1];
        end
        return w;
    endfunction

    // Mostly single-error codewords, some double errors and pure noise.
    function automatic logic [CODE_W-1:0] random_received(input int n);
        logic [CODE_W-1:0] w;
        int kind;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            w = random_word();
        end
        else
        begin
            w = valid_codeword(n);
            if (kind < 85) w[$urandom_range(n - 1, 0)] ^= 1'b1;
            if (kind >= 75) w[$urandom_range(n - 1, 0)] ^= 1'b1;
        end
        // Garbage above the code length must be ignored.
        if ($urandom_range(1)) w = w | (random_word() & ~low_positions(n));
        return w;
    endfunction

    // One item transfer, with an occasional idle gap before it.
    task automatic send_item(input logic act, input logic [DATA_W-1:0] d,
                             input logic [CODE_W-1:0] c);
        int gap;
        if (gaps_on && $urandom_range(99) < 11)
        begin
            gap = $urandom_range(2, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        data_bits <= d;
        received_code <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Hold off until every expected result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Length changes only with the pipeline empty.
    task automatic write_length(input logic [LEN_W-1:0] len);
        drain_results();
        cfg_write <= 1'b1;
        cfg_data <= len;
        cur_len = len;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Watchdog on total run length.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // Main stimulus sequence.
    initial
    begin
        logic [LEN_W-1:0] phase_lens[12];
        int n;
        phase_lens = '{LEN_W'(1), LEN_W'(63), LEN_W'(2), LEN_W'(57), LEN_W'(3), LEN_W'(0),
                       LEN_W'(5), LEN_W'(11), LEN_W'(26), LEN_W'(27), LEN_W'(58), LEN_W'(4)};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset length of four data bits, surplus bits set.
        send_item(ACT_ENCODE, '0, '0);
        send_item(ACT_ENCODE, '1, '0);
        send_item(ACT_ENCODE, DATA_W'(4'b1011), '1);
        send_item(ACT_DECODE, '1, '0);
        send_item(ACT_DECODE, '0, '1);
        send_item(ACT_DECODE, '0, valid_codeword(7) ^ CODE_W'(1 << 2));
        send_item(ACT_DECODE, '0, valid_codeword(7) ^ CODE_W'(1 << 3));

        // A zero length acts as one data bit.
        write_length(LEN_W'(0));
        send_item(ACT_ENCODE, DATA_W'(1), '0);
        send_item(ACT_ENCODE, '1, '1);
        send_item(ACT_DECODE, '0, CODE_W'(3'b111));
        send_item(ACT_DECODE, '0, CODE_W'(3'b001));

        // Five data bits: syndromes above the code length of nine are flagged.
        write_length(LEN_W'(5));
        send_item(ACT_DECODE, '0, CODE_W'((1 << 5) | (1 << 8)));
        send_item(ACT_DECODE, '0, CODE_W'((1 << 8) | (1 << 6)));
        send_item(ACT_ENCODE, '1, '0);

        // Lengths above the maximum act as the maximum.
        write_length(LEN_W'(63));
        send_item(ACT_ENCODE, '1, '0);
        send_item(ACT_ENCODE, '0, '1);
        send_item(ACT_DECODE, '0, '1);
        send_item(ACT_DECODE, '0, valid_codeword(63) ^ (CODE_W'(1) << 62));
        write_length(LEN_W'(57));
        send_item(ACT_ENCODE, DATA_W'({$urandom, $urandom}), '0);
        send_item(ACT_DECODE, '0, '0);
        send_item(ACT_DECODE, '0, valid_codeword(63) ^ CODE_W'(1));

        // Random phases, each at its own length.
        for (int ph = 0; ph < 13; ph++) begin
            if (ph < 12) write_length(phase_lens[ph]);
            else write_length(LEN_W'($urandom_range(63)));
            n = code_length(cur_len);
            gaps_on = (ph != 6);
            for (int k = 0; k < 104; k++) begin
                if (ph == 2 && k == 50) drain_results();
                if ($urandom_range(1))
                    send_item(ACT_ENCODE, DATA_W'({$urandom, $urandom}), random_word());
                else
                    send_item(ACT_DECODE, DATA_W'({$urandom, $urandom}), random_received(n));
            end
        end

        // Let the pipeline empty, then keep watching for stray results.
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
